[sv/thrm_pkg.sv]
// Shared constants, lookup tables and controller command type for the thermistor converter.
package thrm_pkg;

    localparam int ADC_W     = 12;
    localparam int TEMP_W    = 18;
    localparam int FRAC_BITS = 8;
    localparam int TBL_N     = 64;
    localparam int SEG_W     = $clog2(TBL_N);
    localparam int LAST_SEG  = TBL_N - 2;
    localparam int BIT_W     = $clog2(SEG_W);
    localparam int DEG_W     = 10;
    localparam int DY_W      = 9;
    localparam int DX_W      = ADC_W;
    localparam int PROD_W    = DY_W + DX_W;
    localparam int NUM_W     = PROD_W + FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int COEF_W    = 17;
    localparam int Q16_SHIFT = 16;
    localparam int ACC_W     = 36;

    localparam logic [COEF_W-1:0] COEF_FB = 17'd55968;
    localparam logic [COEF_W-1:0] COEF_IN = 17'd4771;

    localparam logic signed [ACC_W-1:0]  ROUND_HALF = 36'sd32768;
    localparam logic signed [TEMP_W-1:0] T_LOW_Q    = -18'sd5120;
    localparam logic signed [TEMP_W-1:0] T_HIGH_Q   = 18'sd76800;

    localparam logic [ADC_W-1:0] TBL_ADC [TBL_N] = '{
        12'd92,   12'd100,  12'd108,  12'd112,  12'd124,  12'd132,  12'd140,  12'd152,
        12'd164,  12'd176,  12'd192,  12'd208,  12'd224,  12'd244,  12'd264,  12'd284,
        12'd312,  12'd336,  12'd368,  12'd400,  12'd436,  12'd480,  12'd524,  12'd572,
        12'd624,  12'd685,  12'd749,  12'd821,  12'd897,  12'd981,  12'd1073, 12'd1173,
        12'd1281, 12'd1393, 12'd1517, 12'd1645, 12'd1781, 12'd1921, 12'd2066, 12'd2214,
        12'd2366, 12'd2514, 12'd2662, 12'd2810, 12'd2950, 12'd3082, 12'd3206, 12'd3322,
        12'd3431, 12'd3527, 12'd3615, 12'd3691, 12'd3759, 12'd3819, 12'd3867, 12'd3911,
        12'd3943, 12'd3975, 12'd3999, 12'd4019, 12'd4035, 12'd4051, 12'd4067, 12'd4083
    };

    localparam logic signed [DEG_W-1:0] TBL_DEG [TBL_N] = '{
        10'sd300, 10'sd295, 10'sd290, 10'sd285, 10'sd280, 10'sd275, 10'sd270, 10'sd265,
        10'sd260, 10'sd255, 10'sd250, 10'sd245, 10'sd240, 10'sd235, 10'sd230, 10'sd225,
        10'sd220, 10'sd215, 10'sd210, 10'sd205, 10'sd200, 10'sd195, 10'sd190, 10'sd185,
        10'sd180, 10'sd175, 10'sd170, 10'sd165, 10'sd160, 10'sd155, 10'sd150, 10'sd145,
        10'sd140, 10'sd135, 10'sd130, 10'sd125, 10'sd120, 10'sd115, 10'sd110, 10'sd105,
        10'sd100, 10'sd95,  10'sd90,  10'sd85,  10'sd80,  10'sd75,  10'sd70,  10'sd65,
        10'sd60,  10'sd55,  10'sd50,  10'sd45,  10'sd40,  10'sd35,  10'sd30,  10'sd25,
        10'sd20,  10'sd15,  10'sd10,  10'sd5,   10'sd0,   -10'sd5,  -10'sd10, -10'sd15
    };

    typedef struct packed {
        logic             load;
        logic             srch;
        logic [BIT_W-1:0] srch_bit;
        logic             prep;
        logic             div_step;
        logic             filt_a;
        logic             filt_b;
        logic             filt_c;
        logic             commit;
    } thrm_cmd_t;

endpackage

[sv/thrm_dp.sv]
// Datapath: segment search, interpolation divider, IIR filter and output registers.
module thrm_dp
    import thrm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  thrm_cmd_t                cmd,
    input  logic [ADC_W-1:0]         adc_sample,
    output logic signed [TEMP_W-1:0] filtered_temp,
    output logic signed [TEMP_W-1:0] converted_temp,
    output logic                     in_range
);

    logic [ADC_W-1:0]         adc_reg;
    logic                     inr_reg;
    logic [SEG_W-1:0]         idx_reg,  idx_next;
    logic [DX_W-1:0]          dx_reg;
    logic                     dxz_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DX_W-1:0]          rem_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic signed [TEMP_W-1:0] base_reg;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic signed [ACC_W-1:0]  p_fb_reg, p_fb_next;
    logic signed [ACC_W-1:0]  p_in_reg, p_in_next;
    logic signed [TEMP_W-1:0] fres_reg, fres_next;
    logic signed [TEMP_W-1:0] filt_reg;
    logic signed [TEMP_W-1:0] prev_reg;
    logic signed [TEMP_W-1:0] out_filt_reg;
    logic signed [TEMP_W-1:0] out_conv_reg;
    logic                     out_inr_reg;

    // search probe
    logic [SEG_W-1:0] probe;
    // interpolation prep
    logic [SEG_W-1:0]         idx_nx;
    logic [ADC_W-1:0]         x0, x1;
    logic signed [DEG_W-1:0]  y0, y1, dy_full;
    logic [DY_W-1:0]          dy;
    logic [DX_W-1:0]          dx, x_gap;
    logic [PROD_W-1:0]        prod;
    logic [NUM_W-1:0]         num_next;
    logic signed [TEMP_W-1:0] base_next;
    // divider step
    logic [DX_W:0]            rem_sh;
    logic                     q_bit;
    logic [DX_W-1:0]          rem_next;
    // filter
    logic signed [TEMP_W:0]   tsum;
    logic signed [ACC_W-1:0]  acc, acc_sh;

    always_comb
    begin
        probe    = idx_reg | (SEG_W'(1) << cmd.srch_bit);
        idx_next = idx_reg;
        if ((probe <= SEG_W'(LAST_SEG)) && (TBL_ADC[probe] <= adc_reg))
        begin
            idx_next = probe;
        end
    end

    always_comb
    begin
        idx_nx    = idx_reg + 1'b1;
        x0        = TBL_ADC[idx_reg];
        x1        = TBL_ADC[idx_nx];
        y0        = TBL_DEG[idx_reg];
        y1        = TBL_DEG[idx_nx];
        dx        = x1 - x0;
        x_gap     = x1 - adc_reg;
        dy_full   = y0 - y1;
        dy        = dy_full[DY_W-1:0];
        prod      = dy * x_gap;
        num_next  = NUM_W'({prod, {FRAC_BITS{1'b0}}}) + NUM_W'(dx >> 1);
        base_next = TEMP_W'(y1) <<< FRAC_BITS;
    end

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        q_bit    = (rem_sh >= {1'b0, dx_reg});
        rem_next = q_bit ? DX_W'(rem_sh - {1'b0, dx_reg}) : rem_sh[DX_W-1:0];
    end

    always_comb
    begin
        if (!inr_reg)
        begin
            temp_next = T_LOW_Q;
        end
        else if (dxz_reg)
        begin
            temp_next = base_reg;
        end
        else
        begin
            temp_next = base_reg + $signed(quo_reg[TEMP_W-1:0]);
        end
        p_fb_next = $signed({1'b0, COEF_FB}) * filt_reg;
        tsum      = $signed({temp_reg[TEMP_W-1], temp_reg})
                  + $signed({prev_reg[TEMP_W-1], prev_reg});
        p_in_next = $signed({1'b0, COEF_IN}) * tsum;
        acc       = p_fb_reg + p_in_reg + ROUND_HALF;
        acc_sh    = acc >>> Q16_SHIFT;
        if (acc_sh < ACC_W'(T_LOW_Q))
        begin
            fres_next = T_LOW_Q;
        end
        else if (acc_sh > ACC_W'(T_HIGH_Q))
        begin
            fres_next = T_HIGH_Q;
        end
        else
        begin
            fres_next = acc_sh[TEMP_W-1:0];
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
            prev_reg <= '0;
        end
        else if (cmd.commit)
        begin
            filt_reg <= fres_reg;
            prev_reg <= temp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            adc_reg <= adc_sample;
            idx_reg <= '0;
            inr_reg <= (adc_sample >= TBL_ADC[0]) && (adc_sample <= TBL_ADC[TBL_N-1]);
        end
        if (cmd.srch)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.prep)
        begin
            dx_reg   <= dx;
            dxz_reg  <= (dx == '0);
            num_reg  <= num_next;
            rem_reg  <= '0;
            quo_reg  <= '0;
            base_reg <= base_next;
        end
        if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
        end
        if (cmd.filt_a)
        begin
            temp_reg <= temp_next;
            p_fb_reg <= p_fb_next;
        end
        if (cmd.filt_b)
        begin
            p_in_reg <= p_in_next;
        end
        if (cmd.filt_c)
        begin
            fres_reg <= fres_next;
        end
        if (cmd.commit)
        begin
            out_filt_reg <= fres_reg;
            out_conv_reg <= temp_reg;
            out_inr_reg  <= inr_reg;
        end
    end

    assign filtered_temp  = out_filt_reg;
    assign converted_temp = out_conv_reg;
    assign in_range       = out_inr_reg;

endmodule

[sv/thrm_ctrl.sv]
// Controller state machine: sequences search, divide and filter steps, owns the handshakes.
module thrm_ctrl
    import thrm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_stall,
    output logic      result_valid,
    input  logic      result_stall,
    output thrm_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SRCH   = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FILT_A = 3'd4;
    localparam logic [2:0] ST_FILT_B = 3'd5;
    localparam logic [2:0] ST_FILT_C = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             vld_reg,   vld_next;
    logic             commit;

    assign commit = (state_reg == ST_DONE) && (!vld_reg || !result_stall);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.srch_bit = cnt_reg[BIT_W-1:0];
        cmd.commit   = commit;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(SEG_W - 1);
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                cmd.srch = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FILT_A;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FILT_A:
            begin
                cmd.filt_a = 1'b1;
                state_next = ST_FILT_B;
            end
            ST_FILT_B:
            begin
                cmd.filt_b = 1'b1;
                state_next = ST_FILT_C;
            end
            ST_FILT_C:
            begin
                cmd.filt_c = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            vld_next = 1'b1;
        end
        else if (result_stall)
        begin
            vld_next = vld_reg;
        end
        else
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = vld_reg;

endmodule

[sv/thermistor_adc_to_filtered_temp.sv]
// Top level of the thermistor ADC to filtered temperature converter.
// Each item is one 12-bit thermistor sample. It is located in a 64-point ADC/temperature
// table by a 6-step binary search, interpolated with a bit-serial restoring divider, and
// passed through a first-order IIR filter, giving one result item with filtered and
// unfiltered signed Q10.8 temperatures and an in-range flag. No new item is accepted
// while one is in progress; the next item is taken the cycle after a result is loaded
// into the output register, which holds it until taken.
// Samples outside the table report a converted temperature of -20 C with in_range low.
// Filter state resets to zero.
module thermistor_adc_to_filtered_temp
    import thrm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic [ADC_W-1:0]         adc_sample,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [TEMP_W-1:0] filtered_temp,
    output logic signed [TEMP_W-1:0] converted_temp,
    output logic                     in_range
);

    thrm_cmd_t cmd;

    thrm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    thrm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .adc_sample     (adc_sample),
        .filtered_temp  (filtered_temp),
        .converted_temp (converted_temp),
        .in_range       (in_range)
    );

endmodule

[dv/testbench.sv]
// Self-checking testbench for thermistor_adc_to_filtered_temp against a table/IIR predictor.
`timescale 1ns / 1ps
module testbench
    import thrm_pkg::*;
();

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 60;
    localparam int     MAX_REPORTS    = 50;
    localparam int     CAL_POINTS     = 64;
    localparam int     DEG_TOP        = 300;
    localparam int     DEG_STEP       = 5;
    localparam longint Q_ONE          = 256;
    localparam longint T_FLOOR_Q      = -20 * 256;
    localparam longint T_CEIL_Q       = 300 * 256;
    localparam longint K_FEEDBACK     = 55968;
    localparam longint K_INPUT        = 4771;
    localparam longint Q16_HALF       = 32768;

    // ADC calibration points; temperature falls 5 C per point starting at 300 C
    localparam int CAL_ADC [CAL_POINTS] = '{
        92,   100,  108,  112,  124,  132,  140,  152,  164,  176,  192,  208,  224,  244,
        264,  284,  312,  336,  368,  400,  436,  480,  524,  572,  624,  685,  749,  821,
        897,  981,  1073, 1173, 1281, 1393, 1517, 1645, 1781, 1921, 2066, 2214, 2366, 2514,
        2662, 2810, 2950, 3082, 3206, 3322, 3431, 3527, 3615, 3691, 3759, 3819, 3867, 3911,
        3943, 3975, 3999, 4019, 4035, 4051, 4067, 4083
    };

    localparam int CORNER_ADC [24] = '{
        0, 4095, 91, 92, 93, 96, 100, 108, 1280, 1281, 1282, 2048,
        2730, 1365, 3999, 4000, 4082, 4083, 4084, 4094, 1, 685, 749, 4067
    };

    typedef struct packed {
        logic signed [TEMP_W-1:0] filt;
        logic signed [TEMP_W-1:0] conv;
        logic                     hit;
    } reading_t;

    logic                     clk;
    logic                     rst_n;
    logic                     sample_valid;
    logic                     sample_stall;
    logic [ADC_W-1:0]         adc_sample;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [TEMP_W-1:0] filtered_temp;
    logic signed [TEMP_W-1:0] converted_temp;
    logic                     in_range;

    reading_t pending_readings [$];
    reading_t due_reading;
    longint   filter_state;
    longint   last_conv;
    int       n_errors    = 0;
    int       idle_cycles = 0;
    int       stall_left  = 0;
    bit       gaps_on;
    bit       stalls_on;

    thermistor_adc_to_filtered_temp u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .adc_sample     (adc_sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .filtered_temp  (filtered_temp),
        .converted_temp (converted_temp),
        .in_range       (in_range)
    );

    always
    begin
        #1 clk = 1'b0;
        #1 clk = 1'b1;
    end

    function automatic reading_t predict_reading(input logic [ADC_W-1:0] adc);
        reading_t r;
        longint   a;
        longint   x0;
        longint   x1;
        longint   dx;
        longint   base;
        longint   temp;
        longint   acc;
        longint   f;
        logic     hit;
        int       i;
        a    = adc;
        temp = T_FLOOR_Q;
        hit  = 1'b0;
        // later segment wins on a shared point
        for (i = 0; i < CAL_POINTS - 1; i++)
        begin
            x0 = CAL_ADC[i];
            x1 = CAL_ADC[i + 1];
            if (a >= x0 && a <= x1)
            begin
                hit  = 1'b1;
                dx   = x1 - x0;
                base = longint'(DEG_TOP - DEG_STEP * (i + 1)) * Q_ONE;
                if (dx <= 0)
                    temp = base;
                else
                    temp = base + (DEG_STEP * (x1 - a) * Q_ONE + dx / 2) / dx;
            end
        end
        acc = K_FEEDBACK * filter_state + K_INPUT * temp + K_INPUT * last_conv;
        f   = (acc + Q16_HALF) >>> 16;
        if (f < T_FLOOR_Q)
            f = T_FLOOR_Q;
        if (f > T_CEIL_Q)
            f = T_CEIL_Q;
        filter_state = f;
        last_conv    = temp;
        r.filt = f[TEMP_W-1:0];
        r.conv = temp[TEMP_W-1:0];
        r.hit  = hit;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [TEMP_W-1:0] got,
                                   input logic signed [TEMP_W-1:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    task automatic send_sample(input logic [ADC_W-1:0] adc);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        adc_sample   <= adc;
        do @(posedge clk); while (sample_stall);
        pending_readings.push_back(predict_reading(adc));
    endtask

    task automatic wait_for_drain();
        sample_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
    endtask

    function automatic logic [ADC_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 3))
            0: v = CAL_ADC[$urandom_range(0, CAL_POINTS - 1)] + $urandom_range(0, 4) - 2;
            1: v = $urandom_range(0, 1) ? $urandom_range(0, CAL_ADC[0] - 1)
                                        : $urandom_range(CAL_ADC[CAL_POINTS - 1] + 1, 4095);
            default: v = $urandom_range(0, 4095);
        endcase
        return v[ADC_W-1:0];
    endfunction

    task automatic test_directed_corners();
        int i;
        for (i = 0; i < 24; i++)
            send_sample(CORNER_ADC[i][ADC_W-1:0]);
    endtask

    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 8; i++)
            send_sample(pick_sample());
        wait_for_drain();
    endtask

    // runs of one value drive the filter toward its hot and cold extremes
    task automatic test_random_samples(input int n_items);
        int               sent;
        int               run_len;
        logic [ADC_W-1:0] v;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_sample(pick_sample());
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: v = CAL_ADC[0][ADC_W-1:0];
                    1: v = '1;
                    default: v = pick_sample();
                endcase
                run_len = $urandom_range(5, 40);
                repeat (run_len) send_sample(v);
                sent += run_len;
            end
        end
    endtask

    task automatic test_steady_stream(input int n_items);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (n_items) send_sample(pick_sample());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("unexpected result", filtered_temp, '0);
            else
            begin
                due_reading = pending_readings.pop_front();
                if (filtered_temp !== due_reading.filt)
                    report_mismatch("filtered_temp", filtered_temp, due_reading.filt);
                if (converted_temp !== due_reading.conv)
                    report_mismatch("converted_temp", converted_temp, due_reading.conv);
                if (in_range !== due_reading.hit)
                    report_mismatch("in_range", TEMP_W'(in_range), TEMP_W'(due_reading.hit));
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                result_stall <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 10);
            result_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        adc_sample   = '0;
        filter_state = 0;
        last_conv    = 0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_drain_pause();
        test_random_samples(1700);
        test_drain_pause();
        test_steady_stream(250);
        sample_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
